// ===== hdl/glu_pkg.sv =====
// Shared constants and controller/datapath interface types for the gcd/lcm unit.
// No dependencies.
package glu_pkg;

	// Fixed field widths of the streaming items
	localparam int unsigned GLU_FIELD_W         = 32;
	localparam int unsigned GLU_VALUE_W         = 64;
	localparam int unsigned GLU_OPERAND_WIDTH   = 32;

	// Command field codes
	localparam logic GLU_CMD_GCD = 1'b0;
	localparam logic GLU_CMD_LCM = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;      // capture a new item
		logic gcd_step;  // one binary gcd reduction
		logic fin_zero;  // error result
		logic fin_gcd;   // latch gcd, arm divider
		logic div_step;  // one restoring division step
		logic mul;       // quotient times operand b
		logic out_load;  // move result into the output register
	} glu_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic zero;      // an operand is zero
		logic equal;     // gcd reduction has converged
		logic lcm;       // item asks for the lcm
		logic div_last;  // final division step
	} glu_status_t;

endpackage

// ===== hdl/glu_ctrl.sv =====
// Sequencing controller for the gcd/lcm unit.
// Depends on glu_pkg (command and status types).
module glu_ctrl
	import glu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_valid,
	output logic        s_ready,
	output logic        m_valid,
	input  logic        m_ready,
	input  glu_status_t st,
	output glu_cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RUN  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   m_valid_q;
	logic   out_free;

	assign s_ready  = (state_q == ST_IDLE);
	assign m_valid  = m_valid_q;
	assign out_free = !m_valid_q || m_ready;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (st.zero) begin
					cmd.fin_zero = 1'b1;
					state_d      = ST_DONE;
				end else if (st.equal) begin
					cmd.fin_gcd = 1'b1;
					state_d     = st.lcm ? ST_DIV : ST_DONE;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)  m_valid_q <= 1'b1;
			else if (m_ready)  m_valid_q <= 1'b0;
		end
	end

	// An accepted item always starts the reduction
	a_accept_run: assert property (@(posedge clk) disable iff (!arst_n)
		(s_valid && s_ready) |=> (state_q == ST_RUN))
		else $error("accepted item did not start the reduction");

	// The last division step is followed by the multiply
	a_div_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && st.div_last) |=> (state_q == ST_MUL))
		else $error("division did not hand over to the multiply");

	// A result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_valid_q || m_ready))
		else $error("pending result overwritten");

endmodule

// ===== hdl/glu_dp.sv =====
// Datapath of the gcd/lcm unit: binary gcd, restoring divider, multiplier
// and output register. Depends on glu_pkg.
module glu_dp
	import glu_pkg::*;
#(
	parameter int unsigned OPERAND_WIDTH = GLU_OPERAND_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [2*GLU_FIELD_W-1:0] s_data,
	input  logic                     s_user,
	input  glu_cmd_t                 cmd,
	output glu_status_t              st,
	output logic [GLU_VALUE_W-1:0]   m_data,
	output logic                     m_user
);

	localparam int unsigned W     = OPERAND_WIDTH;
	localparam int unsigned CNT_W = $clog2(W);

	logic [W-1:0]     x_q, y_q, a_q, b_q, g_q, quo_q, rem_q;
	logic [CNT_W-1:0] k_q, cnt_q;
	logic             lcm_q, zero_q, err_q;
	logic [2*W-1:0]   res_q;

	logic [W-1:0]     in_a, in_b, g_shift, x_minus_y, y_minus_x;
	logic             x_gt_y;
	logic [W:0]       div_shift, div_sub;
	logic             div_ge;

	assign in_a = s_data[W-1:0];
	assign in_b = s_data[GLU_FIELD_W+W-1:GLU_FIELD_W];

	// Reduction arithmetic
	assign x_minus_y = x_q - y_q;
	assign y_minus_x = y_q - x_q;
	assign x_gt_y    = (x_q > y_q);
	assign g_shift   = x_q << k_q;

	// Restoring division: shift in next dividend bit, trial subtract
	assign div_shift = {rem_q, quo_q[W-1]};
	assign div_sub   = div_shift - {1'b0, g_q};
	assign div_ge    = (div_shift >= {1'b0, g_q});

	assign st.zero     = zero_q;
	assign st.equal    = (x_q == y_q);
	assign st.lcm      = (lcm_q == GLU_CMD_LCM);
	assign st.div_last = (cnt_q == CNT_W'(W - 1));

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= in_a;
			y_q    <= in_b;
			a_q    <= in_a;
			b_q    <= in_b;
			k_q    <= '0;
			lcm_q  <= s_user;
			zero_q <= (in_a == '0) || (in_b == '0);
		end
		if (cmd.gcd_step) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_gt_y) begin
				x_q <= x_minus_y >> 1;
			end else begin
				y_q <= y_minus_x >> 1;
			end
		end
		if (cmd.fin_zero) begin
			res_q <= '0;
			err_q <= 1'b1;
		end
		if (cmd.fin_gcd) begin
			g_q   <= g_shift;
			res_q <= (2*W)'(g_shift);
			err_q <= 1'b0;
			rem_q <= '0;
			quo_q <= a_q;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= div_ge ? div_sub[W-1:0] : div_shift[W-1:0];
			quo_q <= {quo_q[W-2:0], div_ge};
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.mul) begin
			res_q <= (2*W)'(quo_q) * (2*W)'(b_q);
		end
		// Output register
		if (cmd.out_load) begin
			m_data <= GLU_VALUE_W'(res_q);
			m_user <= err_q;
		end
	end

	// The binary reduction never reaches a zero operand
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gcd_step |-> (x_q != '0 && y_q != '0))
		else $error("gcd reduction reached zero");

	// Partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < g_q))
		else $error("division remainder out of range");

endmodule

// ===== hdl/gcd_lcm_unit_core.sv =====
// Top level of the gcd/lcm unit: streaming ports, controller and datapath.
// Depends on glu_pkg, glu_ctrl and glu_dp.
//
// Usage:
//   Input item on s_axis: tdata carries operand_a and operand_b, tuser the
//   command (0 gcd, 1 lcm). Output item on m_axis: tdata is the 64-bit
//   value, tuser the zero-operand error flag. One result per input item.
//   Operand bits above OPERAND_WIDTH are ignored.
// Sequence (W = OPERAND_WIDTH):
//   gcd: the item is captured on accept, then binary gcd reduction steps run
//   (one shift or subtract a cycle) until the operands are equal, and the gcd
//   is latched. lcm adds W restoring-division steps (one quotient bit a
//   cycle) and a multiply. A zero operand skips the reduction and gives the error result.
//   One item is in work at a time; the next can be accepted in the cycle
//   after the current result has moved into the output register.
// Reset: arst_n clears the controller to idle with no result pending.
// Stall: a waiting result holds in the output register and the next item
//   can still be accepted and worked on; it waits at the end of its work
//   until the output register is free.
module gcd_lcm_unit_core
	import glu_pkg::*;
#(
	parameter int unsigned OPERAND_WIDTH = GLU_OPERAND_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [2*GLU_FIELD_W-1:0] s_axis_tdata,  // operand_a, operand_b
	input  logic [0:0]               s_axis_tuser,  // command
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [GLU_VALUE_W-1:0]   m_axis_tdata,  // value
	output logic [0:0]               m_axis_tuser   // zero_operand_error
);

	glu_cmd_t    cmd;
	glu_status_t st;

	// Sequencer
	glu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.st      (st),
		.cmd     (cmd)
	);

	// Arithmetic
	glu_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.s_data (s_axis_tdata),
		.s_user (s_axis_tuser[0]),
		.cmd    (cmd),
		.st     (st),
		.m_data (m_axis_tdata),
		.m_user (m_axis_tuser[0])
	);

endmodule
